@@ rtl/core/multi_button_debounce_press_events_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the button debouncer
// Concurrent checks that compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef MULTI_BUTTON_DEBOUNCE_PRESS_EVENTS_DEFINES_SVH
`define MULTI_BUTTON_DEBOUNCE_PRESS_EVENTS_DEFINES_SVH

`ifndef SYNTHESIS
// Checks that a condition holds at every clock edge out of reset.
`define MBD_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("debouncer check failed");
// Checks that the consequent holds in the cycle after the antecedent.
`define MBD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("debouncer check failed");
`else
`define MBD_ASSERT_ALWAYS(lbl, expr)
`define MBD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ rtl/core/mbdpe_pkg.sv @@
// ---------------------------------------------------------------------------
// Button debouncer package
// Request and event payload types and register constants shared by the debouncer.
// ---------------------------------------------------------------------------
package mbdpe_pkg;

    localparam int LEVEL_W = 31;
    localparam int TIME_W  = 32;
    localparam int CFG_W   = 16;
    localparam int CHAN_W  = 5;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    // Register selects, taken from the word address bit paddr[2].
    localparam logic REG_POLL     = 1'b0;
    localparam logic REG_DEBOUNCE = 1'b1;

    localparam logic [CFG_W-1:0] POLL_RESET     = 16'd10;
    localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd30;

    typedef struct packed {
        logic [LEVEL_W-1:0] level_bits;
        logic [TIME_W-1:0]  now_ms;
    } t_in_item;

    typedef struct packed {
        logic [CHAN_W-1:0] pressed_channel;
        logic              last_event;
    } t_out_item;

endpackage

@@ rtl/core/multi_button_debounce_press_events.sv @@
// ---------------------------------------------------------------------------
// Multi-button debouncer with press events
// Debounces sampled active-low button levels and reports new presses.
// ---------------------------------------------------------------------------
// Timing: a request is registered at acceptance and evaluated from that register
// once the event drain is free; its press mask is then registered in the drain.
// Throughput: one request per cycle while no events are pending; a request
// that yields press events occupies the event drain until its last is taken.
// Reset (synchronous, active low) restores both registers to their defaults
// and clears the debounced levels, previous sample, stamps and poll time.
// ---------------------------------------------------------------------------
`include "multi_button_debounce_press_events_defines.svh"

module multi_button_debounce_press_events #(
    parameter int CHANNELS = 31
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Sample requests.
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  mbdpe_pkg::t_in_item        i_in_data,
    // Press events.
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output mbdpe_pkg::t_out_item       o_out_data,
    // Configuration port.
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [mbdpe_pkg::ADDR_W-1:0] paddr,
    input  logic [mbdpe_pkg::DATA_W-1:0] pwdata,
    output logic [mbdpe_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import mbdpe_pkg::*;

    // Configuration registers. Only the word address bit selects a register,
    // so every write lands on one of the two.
    logic [CFG_W-1:0] r_poll_ms;
    logic [CFG_W-1:0] r_debounce_ms;
    logic             cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_ms     <= POLL_RESET;
            r_debounce_ms <= DEBOUNCE_RESET;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_POLL:     r_poll_ms     <= pwdata[CFG_W-1:0];
                REG_DEBOUNCE: r_debounce_ms <= pwdata[CFG_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_POLL:     prdata = {{(DATA_W-CFG_W){1'b0}}, r_poll_ms};
            REG_DEBOUNCE: prdata = {{(DATA_W-CFG_W){1'b0}}, r_debounce_ms};
            default:      prdata = '0;
        endcase
    end

    // Input register. A held request is evaluated when the event drain can
    // take its press mask; until then new requests are stalled.
    logic     r_in_valid;
    t_in_item r_in;
    logic     in_fire;
    logic     consume;
    logic     drain_free;

    assign o_in_stall = r_in_valid && !consume;
    assign in_fire    = i_in_valid && !o_in_stall;
    assign consume    = r_in_valid && drain_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (consume) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in <= i_in_data;
        end
    end

    // Debounce state.
    logic [CHANNELS-1:0] r_stable;
    logic [CHANNELS-1:0] r_prev;
    logic [TIME_W-1:0]   r_stamp [CHANNELS];
    logic [TIME_W-1:0]   r_last_poll;

    logic [TIME_W-1:0]   now;
    logic [TIME_W-1:0]   since_poll;
    logic                poll_ok;
    logic [CHANNELS-1:0] pressed;
    logic [CHANNELS-1:0] changed;
    logic [CHANNELS-1:0] settled;
    logic [CHANNELS-1:0] adopt;
    logic [CHANNELS-1:0] press_mask;
    logic [CHANNELS-1:0] n_stable;
    logic [TIME_W-1:0]   n_stamp [CHANNELS];

    assign now        = r_in.now_ms;
    assign since_poll = now - r_last_poll;
    assign poll_ok    = since_poll >= {{(TIME_W-CFG_W){1'b0}}, r_poll_ms};
    assign pressed    = ~r_in.level_bits[CHANNELS-1:0];
    assign changed    = pressed ^ r_prev;

    // Each channel is independent: restamp on a level change, then adopt the
    // new level once it has persisted for the debounce time.
    always_comb begin
        for (int i = 0; i < CHANNELS; i++) begin
            n_stamp[i] = changed[i] ? now : r_stamp[i];
            settled[i] = (now - n_stamp[i]) >= {{(TIME_W-CFG_W){1'b0}}, r_debounce_ms};
        end
    end

    assign adopt      = settled & (pressed ^ r_stable);
    assign n_stable   = (r_stable & ~adopt) | (adopt & pressed);
    assign press_mask = poll_ok ? (adopt & pressed) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable    <= '0;
            r_prev      <= '0;
            r_last_poll <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_stamp[i] <= '0;
            end
        end else if (consume && poll_ok) begin
            r_stable    <= n_stable;
            r_prev      <= pressed;
            r_last_poll <= now;
            for (int i = 0; i < CHANNELS; i++) begin
                r_stamp[i] <= n_stamp[i];
            end
        end
    end

    // Event drain. The pending press mask is emitted lowest channel first,
    // one event per cycle while the output is not stalled; the event is last when a single bit remains.
    logic [CHANNELS-1:0] r_mask;
    logic [CHANNELS-1:0] lowest;
    logic [CHANNELS-1:0] remaining;
    logic [CHAN_W-1:0]   channel;
    logic                single;
    logic                out_fire;

    assign lowest    = r_mask & (~r_mask + {{(CHANNELS-1){1'b0}}, 1'b1});
    assign remaining = r_mask & ~lowest;
    assign single    = (remaining == '0);

    always_comb begin
        channel = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            channel = channel | (lowest[i] ? CHAN_W'(i + 1) : '0);
        end
    end

    assign o_out_valid                = (r_mask != '0);
    assign o_out_data.pressed_channel = channel;
    assign o_out_data.last_event      = single;
    assign out_fire                   = o_out_valid && !i_out_stall;
    assign drain_free                 = !o_out_valid || (out_fire && single);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (consume) begin
            r_mask <= press_mask;
        end else if (out_fire) begin
            r_mask <= remaining;
        end
    end

    // A request is only evaluated once the drain has room for its events.
    `MBD_ASSERT_ALWAYS(a_consume_free, !consume || !o_out_valid || (out_fire && single))
    // Every pending event belongs to a channel that is now debounced pressed.
    `MBD_ASSERT_NEXT(a_events_stable, consume, (r_mask & ~r_stable) == '0)
    // An event that is not last is always followed by more events.
    `MBD_ASSERT_NEXT(a_more_follow, out_fire && !single, o_out_valid)

endmodule
